FILE: hdl/matrix_inverse_adjugate_defines.svh
// assertion macros used by the matrix inverse rtl
`ifndef MATRIX_INVERSE_ADJUGATE_DEFINES_SVH
`define MATRIX_INVERSE_ADJUGATE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define MIA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define MIA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mia_pkg.sv
// shared types and constants of the matrix inverse block
`default_nettype none
package mia_pkg;

    // parameter defaults
    localparam int MAX_DIM_DEF   = 4;
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int ELEM_W = 8;
    localparam int SIZE_W = 3;
    localparam int IDX_W  = 2;
    localparam int INV_W  = 58;
    localparam int DET_W  = 51;
    localparam int WORK_W = 64;
    // row and column counters cover dimensions up to seven
    localparam int DIM_W  = 3;

    localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);

    typedef enum logic [2:0] {
        T_LOAD,
        T_CALC,
        T_SING,
        T_RD,
        T_LATCH,
        T_DIV,
        T_EMIT
    } t_top_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_SEED,
        E_SCAN,
        E_READ,
        E_MUL,
        E_ACC,
        E_WRITE
    } t_eng_state;

    // control from the sequencer to the minor engine
    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] rd_row;
        logic [DIM_W-1:0] rd_col;
    } t_eng_ctrl;

    // status from the minor engine
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

endpackage
`default_nettype wire

FILE: hdl/matrix_inverse_adjugate.sv
// Matrix inverse by adjugate and determinant. Elements enter one per cycle on
// start while busy is low, row-major, for an n x n matrix (n from i_cfg_data,
// clamped to 2..MAX_DIM; a write drops any partly loaded matrix). After the
// last element busy rises. The minor engine builds the minors of each row
// deletion in a subset table memory over roughly n*(n-1)*2^MAX_DIM scan
// steps plus the terms, each multiply-accumulate term passing through the
// read, multiply and accumulate states; the determinant follows from the
// row-0 cofactors. Each inverse element then goes through the one-bit-
// per-cycle divider. Results come one per strobe cycle, row-major; the
// receiver cannot stall, so each must be taken when o_result_strobe is high.
// A singular matrix gives a single result with o_singular and o_last_result.
`default_nettype none
`include "matrix_inverse_adjugate_defines.svh"
module matrix_inverse_adjugate #(
    parameter int MAX_DIM   = mia_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mia_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [mia_pkg::ELEM_W-1:0]  i_element_value,
    input  wire logic                               i_cfg_we,
    input  wire logic [mia_pkg::SIZE_W-1:0]         i_cfg_data,
    output logic                                    o_result_strobe,
    output logic [mia_pkg::IDX_W-1:0]               o_row_index,
    output logic [mia_pkg::IDX_W-1:0]               o_col_index,
    output logic signed [mia_pkg::INV_W-1:0]        o_inverse_value,
    output logic signed [mia_pkg::DET_W-1:0]        o_det_value,
    output logic                                    o_singular,
    output logic                                    o_last_result
);
    import mia_pkg::*;

    localparam int MDEPTH = MAX_DIM * MAX_DIM;
    localparam int MAW    = $clog2(MDEPTH);
    localparam int CNT_W  = $clog2(MDEPTH + 1);

    t_top_state               r_state, n_state;
    logic [SIZE_W-1:0]        r_size;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [DIM_W-1:0]         r_i, n_i;
    logic [DIM_W-1:0]         r_j, n_j;
    logic [DIM_W-1:0]         n;
    logic [CNT_W-1:0]         total;
    logic                     accept;
    logic                     last_elem;
    logic                     div_start;
    logic                     div_done;
    logic signed [INV_W-1:0]  div_quot;
    logic signed [WORK_W-1:0] det;
    logic signed [WORK_W-1:0] cof;
    t_eng_ctrl                eng_ctrl;
    t_eng_stat                eng_stat;

    // effective size
    always_comb begin
        if (r_size < SIZE_MIN) begin
            n = DIM_W'(SIZE_MIN);
        end else if (r_size > SIZE_W'(MAX_DIM)) begin
            n = DIM_W'(MAX_DIM);
        end else begin
            n = DIM_W'(r_size);
        end
        total     = CNT_W'(n * n);
        accept    = start && !busy;
        last_elem = (r_cnt + CNT_W'(1) == total);
    end

    assign eng_ctrl.start  = accept && last_elem && !eng_stat.busy;
    assign eng_ctrl.n      = n;
    assign eng_ctrl.rd_row = r_j;
    assign eng_ctrl.rd_col = r_i;

    mia_minor #(
        .MAX_DIM (MAX_DIM)
    ) u_minor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (eng_ctrl),
        .i_mat_we   (accept),
        .i_mat_addr (r_cnt[MAW-1:0]),
        .i_mat_data (i_element_value),
        .o_stat     (eng_stat),
        .o_det      (det),
        .o_cof      (cof)
    );

    mia_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (cof),
        .i_den   (det),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // request sequencing and result outputs
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_i             = r_i;
        n_j             = r_j;
        div_start       = 1'b0;
        busy            = 1'b1;
        o_result_strobe = 1'b0;
        o_row_index     = r_i[IDX_W-1:0];
        o_col_index     = r_j[IDX_W-1:0];
        o_inverse_value = div_quot;
        o_det_value     = det[DET_W-1:0];
        o_singular      = 1'b0;
        o_last_result   = 1'b0;
        unique case (r_state)
            T_LOAD: begin
                busy = 1'b0;
                if (accept) begin
                    if (last_elem) begin
                        n_cnt   = '0;
                        n_state = T_CALC;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            T_CALC: begin
                if (eng_stat.done) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = (det == '0) ? T_SING : T_RD;
                end
            end
            T_SING: begin
                o_result_strobe = 1'b1;
                o_row_index     = '0;
                o_col_index     = '0;
                o_inverse_value = '0;
                o_det_value     = '0;
                o_singular      = 1'b1;
                o_last_result   = 1'b1;
                n_state         = T_LOAD;
            end
            T_RD: begin
                n_state = T_LATCH;
            end
            T_LATCH: begin
                div_start = 1'b1;
                n_state   = T_DIV;
            end
            T_DIV: begin
                if (div_done) begin
                    n_state = T_EMIT;
                end
            end
            T_EMIT: begin
                o_result_strobe = 1'b1;
                o_last_result   = (r_i == n - DIM_W'(1)) && (r_j == n - DIM_W'(1));
                if (r_j == n - DIM_W'(1)) begin
                    n_j = '0;
                    n_i = r_i + DIM_W'(1);
                end else begin
                    n_j = r_j + DIM_W'(1);
                end
                n_state = o_last_result ? T_LOAD : T_RD;
            end
            default: n_state = T_LOAD;
        endcase
        if (i_cfg_we) begin
            n_cnt = '0;
        end
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_LOAD;
            r_cnt   <= '0;
            r_size  <= SIZE_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
        end
        r_i <= n_i;
        r_j <= n_j;
    end

    // checks
    `MIA_ASSERT_IMPL(a_sing_last, o_result_strobe && o_singular, o_last_result, "singular result not last")
    `MIA_ASSERT_IMPL(a_strobe_busy, o_result_strobe, busy, "result while idle")
    `MIA_ASSERT_NEXT(a_full_busy, accept && last_elem, busy && eng_stat.busy, "engine not started")

endmodule
`default_nettype wire

FILE: hdl/mia_minor.sv
// minor engine: element memory, minor table memory and the cofactor sweep
`default_nettype none
module mia_minor #(
    parameter int MAX_DIM = mia_pkg::MAX_DIM_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire mia_pkg::t_eng_ctrl                    i_ctrl,
    input  wire logic                                  i_mat_we,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    i_mat_addr,
    input  wire logic signed [mia_pkg::ELEM_W-1:0]     i_mat_data,
    output mia_pkg::t_eng_stat                         o_stat,
    output logic signed [mia_pkg::WORK_W-1:0]          o_det,
    output logic signed [mia_pkg::WORK_W-1:0]          o_cof
);
    import mia_pkg::*;

    localparam int NSUB     = 1 << MAX_DIM;
    localparam int MDEPTH   = MAX_DIM * MAX_DIM;
    localparam int MAW      = $clog2(MDEPTH);
    localparam int TDEPTH   = NSUB + MDEPTH;
    localparam int TAW      = $clog2(TDEPTH);
    localparam int CW       = $clog2(MAX_DIM);

    // memories
    logic signed [ELEM_W-1:0] r_mat [MDEPTH];
    logic signed [WORK_W-1:0] r_tab [TDEPTH];
    logic signed [ELEM_W-1:0] r_mat_q;
    logic signed [WORK_W-1:0] r_tab_q;

    t_eng_state               r_state, n_state;
    logic [DIM_W-1:0]         r_pass, n_pass;
    logic [DIM_W-1:0]         r_level, n_level;
    logic                     r_det_lvl, n_det_lvl;
    logic [MAX_DIM-1:0]       r_sub, n_sub;
    logic [CW-1:0]            r_col, n_col;
    logic signed [WORK_W-1:0] r_acc, n_acc;
    logic signed [WORK_W-1:0] r_prod;
    logic                     r_neg;
    logic signed [WORK_W-1:0] r_det, n_det;
    logic                     r_done, n_done;

    logic [MAX_DIM-1:0]       full_mask;
    logic [DIM_W-1:0]         pop_sub;
    logic [DIM_W-1:0]         pop_low;
    logic [DIM_W-1:0]         miss_col;
    logic                     sub_ok;
    logic                     final_lvl;
    logic                     col_last;
    logic                     term_neg;
    logic [DIM_W-1:0]         row_sel;
    logic [5:0]               mat_lin;
    logic [MAW-1:0]           mat_raddr;
    logic [TAW-1:0]           tab_raddr;
    logic                     tab_we;
    logic [TAW-1:0]           tab_waddr;
    logic signed [WORK_W-1:0] tab_wdata;
    logic                     cof_neg;

    // subset bookkeeping: population counts and the missing column
    always_comb begin
        full_mask = ~({MAX_DIM{1'b1}} << i_ctrl.n);
        pop_sub   = '0;
        pop_low   = '0;
        miss_col  = '0;
        for (int b = 0; b < MAX_DIM; b++) begin
            if (r_sub[b]) begin
                pop_sub = pop_sub + DIM_W'(1);
            end
            if (r_sub[b] && (CW'(b) < r_col)) begin
                pop_low = pop_low + DIM_W'(1);
            end
            if (!r_sub[b] && (DIM_W'(b) < i_ctrl.n)) begin
                miss_col = DIM_W'(b);
            end
        end
    end

    // which subset and row the current level works on
    always_comb begin
        final_lvl = !r_det_lvl && (r_level == i_ctrl.n - DIM_W'(1));
        col_last  = (r_col == CW'(MAX_DIM - 1));
        if (r_det_lvl) begin
            sub_ok  = (r_sub == full_mask);
            row_sel = '0;
        end else begin
            sub_ok  = ((r_sub & ~full_mask) == '0) && (pop_sub == r_level);
            row_sel = ((r_level - DIM_W'(1)) < r_pass) ? (r_level - DIM_W'(1)) : r_level;
        end
        term_neg  = r_det_lvl ? 1'b0 : (r_level[0] ^ 1'b1 ^ pop_low[0]);
        mat_lin   = 6'(row_sel * i_ctrl.n) + 6'(r_col);
        mat_raddr = mat_lin[MAW-1:0];
        if (r_state == E_IDLE) begin
            tab_raddr = TAW'(NSUB + int'(i_ctrl.rd_row) * MAX_DIM + int'(i_ctrl.rd_col));
        end else if (r_det_lvl) begin
            tab_raddr = TAW'(NSUB + int'(r_col));
        end else begin
            tab_raddr = TAW'(r_sub & ~(MAX_DIM'(1) << r_col));
        end
    end

    // write port of the minor table
    always_comb begin
        cof_neg   = r_pass[0] ^ miss_col[0];
        tab_we    = 1'b0;
        tab_waddr = '0;
        tab_wdata = r_acc;
        if (r_state == E_SEED) begin
            tab_we    = 1'b1;
            tab_wdata = WORK_W'(1);
        end else if (r_state == E_WRITE && !r_det_lvl) begin
            tab_we = 1'b1;
            if (final_lvl) begin
                tab_waddr = TAW'(NSUB + int'(r_pass) * MAX_DIM + int'(miss_col));
                tab_wdata = cof_neg ? -r_acc : r_acc;
            end else begin
                tab_waddr = TAW'(r_sub);
            end
        end
    end

    // element memory
    always_ff @(posedge i_clk) begin
        if (i_mat_we) begin
            r_mat[i_mat_addr] <= i_mat_data;
        end
        r_mat_q <= r_mat[mat_raddr];
    end

    // minor table memory
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_waddr] <= tab_wdata;
        end
        r_tab_q <= r_tab[tab_raddr];
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (r_state == E_MUL) begin
            r_prod <= WORK_W'(r_mat_q * r_tab_q);
            r_neg  <= term_neg;
        end
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_pass    = r_pass;
        n_level   = r_level;
        n_det_lvl = r_det_lvl;
        n_sub     = r_sub;
        n_col     = r_col;
        n_acc     = r_acc;
        n_det     = r_det;
        n_done    = 1'b0;
        unique case (r_state)
            E_IDLE: begin
                if (i_ctrl.start) begin
                    n_state = E_SEED;
                end
            end
            E_SEED: begin
                n_pass    = '0;
                n_level   = DIM_W'(1);
                n_det_lvl = 1'b0;
                n_sub     = '0;
                n_state   = E_SCAN;
            end
            E_SCAN: begin
                if (sub_ok) begin
                    n_acc   = '0;
                    n_col   = '0;
                    n_state = E_READ;
                end else begin
                    n_sub = r_sub + MAX_DIM'(1);
                    if (r_sub == {MAX_DIM{1'b1}}) begin
                        if (final_lvl) begin
                            if (r_pass == i_ctrl.n - DIM_W'(1)) begin
                                n_det_lvl = 1'b1;
                            end else begin
                                n_pass  = r_pass + DIM_W'(1);
                                n_level = DIM_W'(1);
                            end
                        end else begin
                            n_level = r_level + DIM_W'(1);
                        end
                    end
                end
            end
            E_READ: begin
                if (r_sub[r_col]) begin
                    n_state = E_MUL;
                end else if (col_last) begin
                    n_state = E_WRITE;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            E_MUL: begin
                n_state = E_ACC;
            end
            E_ACC: begin
                n_acc = r_neg ? (r_acc - r_prod) : (r_acc + r_prod);
                if (col_last) begin
                    n_state = E_WRITE;
                end else begin
                    n_col   = r_col + CW'(1);
                    n_state = E_READ;
                end
            end
            E_WRITE: begin
                if (r_det_lvl) begin
                    n_det   = r_acc;
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end else begin
                    n_state = E_SCAN;
                    n_sub   = r_sub + MAX_DIM'(1);
                    if (r_sub == {MAX_DIM{1'b1}}) begin
                        if (final_lvl) begin
                            if (r_pass == i_ctrl.n - DIM_W'(1)) begin
                                n_det_lvl = 1'b1;
                            end else begin
                                n_pass  = r_pass + DIM_W'(1);
                                n_level = DIM_W'(1);
                            end
                        end else begin
                            n_level = r_level + DIM_W'(1);
                        end
                    end
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
            r_det   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_det   <= n_det;
        end
        r_pass    <= n_pass;
        r_level   <= n_level;
        r_det_lvl <= n_det_lvl;
        r_sub     <= n_sub;
        r_col     <= n_col;
        r_acc     <= n_acc;
    end

    assign o_stat.busy = (r_state != E_IDLE);
    assign o_stat.done = r_done;
    assign o_det       = r_det;
    assign o_cof       = r_tab_q;

endmodule
`default_nettype wire

FILE: hdl/mia_div.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
`default_nettype none
module mia_div #(
    parameter int FRAC_BITS = mia_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [mia_pkg::WORK_W-1:0]   i_num,
    input  wire logic signed [mia_pkg::WORK_W-1:0]   i_den,
    output logic                                     o_done,
    output logic signed [mia_pkg::INV_W-1:0]         o_quot
);
    import mia_pkg::*;

    localparam int NW  = WORK_W + FRAC_BITS;
    localparam int NCW = $clog2(NW + 1);

    logic              r_busy;
    logic [NCW-1:0]    r_cnt;
    logic [WORK_W:0]   r_rem;
    logic [NW-1:0]     r_quo;
    logic [WORK_W-1:0] r_den;
    logic              r_neg;
    logic              r_done;
    logic signed [INV_W-1:0] r_quot;

    logic [WORK_W-1:0] num_mag;
    logic [WORK_W-1:0] den_mag;
    logic [WORK_W:0]   rem_sh;
    logic [WORK_W:0]   diff;
    logic [NW-1:0]     quo_next;
    logic [NW-1:0]     quo_signed;

    // operand magnitudes and one restoring step
    always_comb begin
        num_mag    = i_num[WORK_W-1] ? WORK_W'(-i_num) : WORK_W'(i_num);
        den_mag    = i_den[WORK_W-1] ? WORK_W'(-i_den) : WORK_W'(i_den);
        rem_sh     = {r_rem[WORK_W-1:0], r_quo[NW-1]};
        diff       = rem_sh - {1'b0, r_den};
        quo_next   = {r_quo[NW-2:0], ~diff[WORK_W]};
        quo_signed = r_neg ? -quo_next : quo_next;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + NCW'(1);
                if (r_cnt == NCW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= {num_mag, {FRAC_BITS{1'b0}}};
            r_den <= den_mag;
            r_neg <= i_num[WORK_W-1] ^ i_den[WORK_W-1];
        end else if (r_busy) begin
            r_rem <= diff[WORK_W] ? rem_sh : diff;
            r_quo <= quo_next;
            if (r_cnt == NCW'(NW - 1)) begin
                r_quot <= quo_signed[INV_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire
